### rtl/eas_pkg.sv
// Package: shared widths, constants and register indexes of the envelope slicer.
package eas_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam int unsigned TICK_BITS   = 32;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned DECAY_BITS  = 16;
  localparam int unsigned NOISE_BITS  = 18;
  localparam int unsigned HYST_BITS   = 10;
  localparam int unsigned CFG_DATA_W  = 18;
  localparam int unsigned CFG_ADDR_W  = 3;

  // 0.10 in Q0.10, 0.02 as 82/4096
  localparam int unsigned TENTH_Q10   = 102;
  localparam int unsigned ADAPT_NUM   = 82;
  localparam int unsigned ADAPT_SHIFT = 12;
  localparam int unsigned HYST_SHIFT  = 10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PEAK_DECAY   = 3'd0,
    CFG_VALLEY_RISE  = 3'd1,
    CFG_NOISE_WINDOW = 3'd2,
    CFG_ADAPT_EN     = 3'd3,
    CFG_HYST_MARGIN  = 3'd4
  } cfg_idx_e;

endpackage

### rtl/envelope_adaptive_slicer_top.sv
// Top level: envelope-tracking hysteresis slicer with a four-register pipeline.
//
// Input words arrive on the s_axis channel: tdata carries the ADC sample and the
// tick at the start of the current sample block, tlast marks the last sample of a
// block. Each input word yields exactly one result word on m_axis: the sliced level,
// an edge flag with its tick, the running edge count, the DC level and amplitude.
// Configuration registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the
// user must write them only while the block is idle, which the block does not enforce.
// Order: the input register loads the accepted word, and the envelope stage, the
// product stage and the result register follow it in turn.
// Throughput: one word per cycle while the receiver accepts; the envelope update is a
// loop closed within stage 1 and the level decision is a loop closed in the last stage.
// Reset sets both envelopes to mid-scale, the level and the edge count to zero and
// clears config, offset and pipeline valids. When the receiver stalls, stages fill up
// behind the result register; s_axis_tready drops only once every stage holds a word.
module envelope_adaptive_slicer_top #(
  parameter int unsigned SAMPLE_BITS = eas_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = eas_pkg::FRAC_BITS_DEF,
  localparam int unsigned ENV_BITS   = SAMPLE_BITS + 1 + FRAC_BITS,
  localparam int unsigned IN_RAW_W   = SAMPLE_BITS + eas_pkg::TICK_BITS,
  localparam int unsigned IN_W       = ((IN_RAW_W + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W  = 2 + eas_pkg::TICK_BITS + eas_pkg::COUNT_BITS
                                       + 2 * ENV_BITS,
  localparam int unsigned OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // sample, block_tick
  input  logic                            s_axis_tlast,  // last_of_block
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bit_state, edge_res, edge_tick, edge_total, dc_level, amplitude
  output logic [OUT_W-1:0]                m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [eas_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [eas_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned SMP_W    = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned SUM_W    = (ENV_BITS > eas_pkg::DECAY_BITS ? ENV_BITS
                                                                     : eas_pkg::DECAY_BITS) + 1;
  localparam int unsigned HI_P_W   = ENV_BITS + eas_pkg::HYST_BITS;
  localparam int unsigned LO_P_W   = ENV_BITS + eas_pkg::HYST_BITS + 1;
  localparam int unsigned AD_P_W   = ENV_BITS + 7;
  localparam int unsigned AD_W     = AD_P_W - eas_pkg::ADAPT_SHIFT;
  localparam int unsigned HI_W     = HI_P_W - eas_pkg::HYST_SHIFT;
  localparam int unsigned LO_W     = LO_P_W - eas_pkg::HYST_SHIFT;
  localparam int unsigned NZ_W     = (AD_W > eas_pkg::NOISE_BITS ? AD_W
                                                                 : eas_pkg::NOISE_BITS) + 1;
  localparam int unsigned TH_W     = (ENV_BITS > NZ_W ? ENV_BITS : NZ_W) + 3;
  localparam logic [ENV_BITS-1:0] ENV_MAX   = {ENV_BITS{1'b1}};
  localparam logic [ENV_BITS-1:0] ENV_RESET = ENV_BITS'(1) << (SAMPLE_BITS - 1 + FRAC_BITS);
  localparam logic [SUM_W-1:0]    ONE_LSB   = SUM_W'(1) << FRAC_BITS;

  // configuration
  logic [eas_pkg::DECAY_BITS-1:0] peak_decay_q, valley_rise_q;
  logic [eas_pkg::NOISE_BITS-1:0] noise_window_q;
  logic                           adapt_en_q;
  logic [eas_pkg::HYST_BITS-1:0]  hyst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_decay_q   <= '0;
      valley_rise_q  <= '0;
      noise_window_q <= '0;
      adapt_en_q     <= 1'b0;
      hyst_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (eas_pkg::cfg_idx_e'(cfg_addr_i))
        eas_pkg::CFG_PEAK_DECAY:   peak_decay_q   <= cfg_wdata_i[eas_pkg::DECAY_BITS-1:0];
        eas_pkg::CFG_VALLEY_RISE:  valley_rise_q  <= cfg_wdata_i[eas_pkg::DECAY_BITS-1:0];
        eas_pkg::CFG_NOISE_WINDOW: noise_window_q <= cfg_wdata_i[eas_pkg::NOISE_BITS-1:0];
        eas_pkg::CFG_ADAPT_EN:     adapt_en_q     <= cfg_wdata_i[0];
        eas_pkg::CFG_HYST_MARGIN:  hyst_q         <= cfg_wdata_i[eas_pkg::HYST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign rdy0          = !v0_q || rdy1;
  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 0: input register
  logic [SAMPLE_BITS-1:0]         smp0_q;
  logic [eas_pkg::TICK_BITS-1:0]  tick0_q;
  logic                           last0_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      smp0_q  <= s_axis_tdata[SAMPLE_BITS-1:0];
      tick0_q <= s_axis_tdata[SAMPLE_BITS +: eas_pkg::TICK_BITS];
      last0_q <= s_axis_tlast;
    end
  end

  // stage 1: envelope update
  logic [ENV_BITS-1:0]              peak_q, peak_d, valley_q, valley_d;
  logic [eas_pkg::OFFSET_BITS-1:0]  offset_q, offset_d;
  logic [ENV_BITS-1:0]              smp_ext, pk_a, vl_a;
  logic [SUM_W-1:0]                 vl_sum, pk_fix;
  logic [ENV_BITS:0]                dc_sum;
  logic                             adv1;

  assign adv1 = v0_q && rdy1;

  always_comb begin
    smp_ext = ENV_BITS'({smp0_q, {FRAC_BITS{1'b0}}});
    pk_a    = (smp_ext > peak_q)   ? smp_ext : peak_q;
    vl_a    = (smp_ext < valley_q) ? smp_ext : valley_q;
    if (SUM_W'(pk_a) > SUM_W'(peak_decay_q)) begin
      peak_d = ENV_BITS'(SUM_W'(pk_a) - SUM_W'(peak_decay_q));
    end else begin
      peak_d = '0;
    end
    vl_sum   = SUM_W'(vl_a) + SUM_W'(valley_rise_q);
    valley_d = (vl_sum > SUM_W'(ENV_MAX)) ? ENV_MAX : vl_sum[ENV_BITS-1:0];
    pk_fix   = SUM_W'(valley_d) + ONE_LSB;
    if (peak_d < valley_d) begin
      peak_d = (pk_fix > SUM_W'(ENV_MAX)) ? ENV_MAX : pk_fix[ENV_BITS-1:0];
    end
    dc_sum   = {1'b0, peak_d} + {1'b0, valley_d};
    offset_d = last0_q ? '0 : offset_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= ENV_RESET;
      valley_q <= ENV_RESET;
      offset_q <= '0;
    end else if (adv1) begin
      peak_q   <= peak_d;
      valley_q <= valley_d;
      offset_q <= offset_d;
    end
  end

  logic [SMP_W-1:0]               smp1_q;
  logic [eas_pkg::TICK_BITS-1:0]  etick1_q;
  logic [ENV_BITS-1:0]            peak1_q, amp1_q, dc1_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      smp1_q   <= {smp0_q, {FRAC_BITS{1'b0}}};
      etick1_q <= tick0_q + eas_pkg::TICK_BITS'(offset_q);
      peak1_q  <= peak_d;
      amp1_q   <= peak_d - valley_d;
      dc1_q    <= dc_sum[ENV_BITS:1];
    end
  end

  // stage 2: threshold products
  logic [HI_P_W-1:0] hi_prod;
  logic [LO_P_W-1:0] lo_prod;
  logic [AD_P_W-1:0] ad_prod;

  always_comb begin
    hi_prod = HI_P_W'(amp1_q) * HI_P_W'(hyst_q);
    lo_prod = LO_P_W'(amp1_q) * (LO_P_W'(hyst_q) + LO_P_W'(eas_pkg::TENTH_Q10));
    ad_prod = AD_P_W'(amp1_q) * AD_P_W'(eas_pkg::ADAPT_NUM);
  end

  logic [SMP_W-1:0]               smp2_q;
  logic [eas_pkg::TICK_BITS-1:0]  etick2_q;
  logic [ENV_BITS-1:0]            peak2_q, amp2_q, dc2_q;
  logic [HI_W-1:0]                hi2_q;
  logic [LO_W-1:0]                lo2_q;
  logic [AD_W-1:0]                ad2_q;

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      smp2_q   <= smp1_q;
      etick2_q <= etick1_q;
      peak2_q  <= peak1_q;
      amp2_q   <= amp1_q;
      dc2_q    <= dc1_q;
      hi2_q    <= hi_prod[HI_P_W-1:eas_pkg::HYST_SHIFT];
      lo2_q    <= lo_prod[LO_P_W-1:eas_pkg::HYST_SHIFT];
      ad2_q    <= ad_prod[AD_P_W-1:eas_pkg::ADAPT_SHIFT];
    end
  end

  // stage 3: thresholds, hysteresis, edge bookkeeping
  logic                           adv3;
  logic [NZ_W-1:0]                noise;
  logic signed [TH_W-1:0]         th_high, th_low, smp_s;
  logic                           level_q, level_d, edge_d;
  logic [eas_pkg::COUNT_BITS-1:0] count_q, count_d;

  assign adv3 = v2_q && rdy3;

  always_comb begin
    noise   = NZ_W'(noise_window_q) + (adapt_en_q ? NZ_W'(ad2_q) : '0);
    th_high = signed'(TH_W'(peak2_q)) - signed'(TH_W'(hi2_q)) - signed'(TH_W'(noise));
    th_low  = signed'(TH_W'(peak2_q)) - signed'(TH_W'(lo2_q)) - signed'(TH_W'(noise));
    smp_s   = signed'(TH_W'(smp2_q));
    level_d = level_q;
    if (!level_q && (smp_s > th_high)) begin
      level_d = 1'b1;
    end else if (level_q && (smp_s < th_low)) begin
      level_d = 1'b0;
    end
    edge_d  = level_d != level_q;
    count_d = count_q + eas_pkg::COUNT_BITS'(edge_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      count_q <= '0;
    end else if (adv3) begin
      level_q <= level_d;
      count_q <= count_d;
    end
  end

  logic                           edge3_q;
  logic [eas_pkg::TICK_BITS-1:0]  etick3_q;
  logic [ENV_BITS-1:0]            amp3_q, dc3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      edge3_q  <= edge_d;
      etick3_q <= edge_d ? etick2_q : '0;
      amp3_q   <= amp2_q;
      dc3_q    <= dc2_q;
    end
  end

  assign m_axis_tdata = OUT_W'({amp3_q, dc3_q, count_q, etick3_q, edge3_q, level_q});

endmodule
